@@ src/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: command and status
// codes, and the control word broadcast to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_APPEND,
    OP_SHIFT_OUT
  } cell_op_t;

  typedef struct packed {
    cell_op_t a_op;
    cell_op_t b_op;
    logic     grow;
    logic     shrink;
  } cell_ctrl_t;

  localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

endpackage

`default_nettype wire

@@ src/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the queue. Holds the word at this position in front order
// (chain a) and in rear order (chain b), plus an occupied flag. Trades words
// with its neighbors as the broadcast control word directs.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  deq_pkg::cell_ctrl_t    ctrl,
  input  wire  [deq_pkg::WORD_W-1:0]   push_value,
  input  wire  [deq_pkg::WORD_W-1:0]   left_a,
  input  wire  [deq_pkg::WORD_W-1:0]   left_b,
  input  wire                          left_occ,
  input  wire  [deq_pkg::WORD_W-1:0]   right_a,
  input  wire  [deq_pkg::WORD_W-1:0]   right_b,
  input  wire                          right_occ,
  output logic [deq_pkg::WORD_W-1:0]   a_q,
  output logic [deq_pkg::WORD_W-1:0]   b_q,
  output logic                         occ_q
);

  logic [deq_pkg::WORD_W-1:0] a_r, a_nxt;
  logic [deq_pkg::WORD_W-1:0] b_r, b_nxt;
  logic                       occ_r, occ_nxt;
  logic                       first_free;

  assign first_free = !occ_r && left_occ;

  always_comb begin
    case (ctrl.a_op)
      deq_pkg::OP_INSERT:    a_nxt = left_a;
      deq_pkg::OP_APPEND:    a_nxt = first_free ? push_value : a_r;
      deq_pkg::OP_SHIFT_OUT: a_nxt = right_a;
      default:               a_nxt = a_r;
    endcase
    case (ctrl.b_op)
      deq_pkg::OP_INSERT:    b_nxt = left_b;
      deq_pkg::OP_APPEND:    b_nxt = first_free ? push_value : b_r;
      deq_pkg::OP_SHIFT_OUT: b_nxt = right_b;
      default:               b_nxt = b_r;
    endcase
    if (ctrl.grow) begin
      occ_nxt = left_occ;
    end else if (ctrl.shrink) begin
      occ_nxt = right_occ;
    end else begin
      occ_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign a_q   = a_r;
  assign b_q   = b_r;
  assign occ_q = occ_r;

endmodule

`default_nettype wire

@@ src/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit words held in a row of DEPTH cells. Chain a keeps
// the front word in cell 0, chain b keeps the rear word in cell 0, so every
// pop reads cell 0 and cells trade words only with neighbors, plus the push.
// The result word of an accepted command is registered in the next cycle.
// Throughput: 1 command per cycle; input stalls only while a result waits.
// Reset empties the queue (occupied flags and count cleared); slot words
// are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire  [deq_pkg::CMD_W-1:0]         in_cmd,
  input  wire  signed [deq_pkg::WORD_W-1:0] in_push_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [deq_pkg::WORD_W-1:0] out_pop_value,
  output logic [deq_pkg::STATUS_W-1:0]      out_status,
  output logic [CNT_W-1:0]                  out_occupancy
);

  logic [deq_pkg::WORD_W-1:0] a_q [DEPTH];
  logic [deq_pkg::WORD_W-1:0] b_q [DEPTH];
  logic [DEPTH-1:0]           occ_q;

  deq_pkg::cell_ctrl_t        ctrl;
  deq_pkg::cmd_t              cmd;
  deq_pkg::status_t           status;
  logic [deq_pkg::WORD_W-1:0] popped;
  logic                       accept;
  logic                       full;
  logic                       empty;

  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       out_valid_r;
  logic [deq_pkg::WORD_W-1:0] out_pop_value_r;
  logic [deq_pkg::STATUS_W-1:0] out_status_r;
  logic [CNT_W-1:0]           out_occupancy_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cmd      = deq_pkg::cmd_t'(in_cmd);
  assign full     = occ_q[DEPTH-1];
  assign empty    = !occ_q[0];

  always_comb begin
    ctrl.a_op   = deq_pkg::OP_HOLD;
    ctrl.b_op   = deq_pkg::OP_HOLD;
    ctrl.grow   = 1'b0;
    ctrl.shrink = 1'b0;
    status      = deq_pkg::ST_DONE;
    popped      = '0;
    unique case (cmd)
      deq_pkg::CMD_PUSH_REAR: begin
        if (full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          ctrl.a_op = deq_pkg::OP_APPEND;
          ctrl.b_op = deq_pkg::OP_INSERT;
          ctrl.grow = accept;
        end
      end
      deq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          status = deq_pkg::ST_FULL;
        end else begin
          ctrl.a_op = deq_pkg::OP_INSERT;
          ctrl.b_op = deq_pkg::OP_APPEND;
          ctrl.grow = accept;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          status = deq_pkg::ST_EMPTY;
          popped = deq_pkg::EMPTY_WORD;
        end else begin
          popped      = a_q[0];
          ctrl.a_op   = deq_pkg::OP_SHIFT_OUT;
          ctrl.shrink = accept;
        end
      end
      deq_pkg::CMD_POP_REAR: begin
        if (empty) begin
          status = deq_pkg::ST_EMPTY;
          popped = deq_pkg::EMPTY_WORD;
        end else begin
          popped      = b_q[0];
          ctrl.b_op   = deq_pkg::OP_SHIFT_OUT;
          ctrl.shrink = accept;
        end
      end
      default: begin
        status = deq_pkg::ST_DONE;
      end
    endcase
    if (!accept) begin
      ctrl.a_op = deq_pkg::OP_HOLD;
      ctrl.b_op = deq_pkg::OP_HOLD;
    end
  end

  always_comb begin
    if (ctrl.grow) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.shrink) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [deq_pkg::WORD_W-1:0] left_a, left_b, right_a, right_b;
    logic                       left_occ, right_occ;

    if (i == 0) begin : g_first
      assign left_a   = in_push_value;
      assign left_b   = in_push_value;
      assign left_occ = 1'b1;
    end else begin : g_inner_l
      assign left_a   = a_q[i-1];
      assign left_b   = b_q[i-1];
      assign left_occ = occ_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_a   = '0;
      assign right_b   = '0;
      assign right_occ = 1'b0;
    end else begin : g_inner_r
      assign right_a   = a_q[i+1];
      assign right_b   = b_q[i+1];
      assign right_occ = occ_q[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .push_value (in_push_value),
      .left_a     (left_a),
      .left_b     (left_b),
      .left_occ   (left_occ),
      .right_a    (right_a),
      .right_b    (right_b),
      .right_occ  (right_occ),
      .a_q        (a_q[i]),
      .b_q        (b_q[i]),
      .occ_q      (occ_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pop_value_r <= popped;
      out_status_r    <= status;
      out_occupancy_r <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

endmodule

`default_nettype wire
